// ----- rtl/core/pcrc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcrc_pkg
// Types, codes and helpers shared by the CRC engine front, queue and back.
// ----------------------------------------------------------------------------
package pcrc_pkg;

  localparam int FifoDepth = 16;
  localparam int FifoAw    = 4;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_TICK  = 3'd1,
    OP_GO    = 3'd2,
    OP_SEED  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CFG_ENABLE       = 3'd0,
    CFG_WORD_BITS    = 3'd1,
    CFG_POLY_WIDTH   = 3'd2,
    CFG_POLYNOMIAL   = 3'd3,
    CFG_LSB_FIRST    = 3'd4,
    CFG_IRQ_ON_EMPTY = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUSH,
    CMD_TICK,
    CMD_GO,
    CMD_SEED,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    logic        enable;
    logic [5:0]  word_bits;
    logic [5:0]  poly_width;
    logic [31:0] polynomial;
    logic        lsb_first;
    logic        irq_on_empty;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] data;
    logic        hold;
  } cmd_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic [4:0]  words_queued;
    logic        queue_empty;
    logic        queue_full;
    logic        go_flag;
    logic        busy_res;
    logic        interrupt_pulse;
    logic        word_dropped;
  } res_t;

  function automatic logic [5:0] clamp_width(input logic [5:0] w);
    if (w == 6'd0) begin
      return 6'd1;
    end else if (w > 6'd32) begin
      return 6'd32;
    end
    return w;
  endfunction

  function automatic logic [31:0] width_mask(input logic [5:0] w);
    if (w >= 6'd32) begin
      return 32'hFFFF_FFFF;
    end
    return (32'd1 << w[4:0]) - 32'd1;
  endfunction

  function automatic logic [4:0] capacity(input logic [5:0] dw);
    logic [5:0] w;
    w = clamp_width(dw);
    if (w <= 6'd8) begin
      return 5'd16;
    end else if (w <= 6'd16) begin
      return 5'd8;
    end
    return 5'd4;
  endfunction

endpackage

// ----- rtl/core/pcrc_front.sv -----
// ----------------------------------------------------------------------------
// pcrc_front
// Accepts input beats, decodes the operation and masks pushed data.
// ----------------------------------------------------------------------------
module pcrc_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_operation,
  input  logic [31:0]         in_data_word,
  input  logic                in_hold,
  input  pcrc_pkg::cfg_t      cfg,
  output logic                q_push,
  input  logic                q_full,
  output pcrc_pkg::cmd_t      q_cmd
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.data = in_data_word;
    q_cmd.hold = in_hold;
    unique case (in_operation)
      pcrc_pkg::OP_PUSH: begin
        q_cmd.kind = pcrc_pkg::CMD_PUSH;
        q_cmd.data = in_data_word
                   & pcrc_pkg::width_mask(pcrc_pkg::clamp_width(cfg.word_bits));
      end
      pcrc_pkg::OP_TICK:  q_cmd.kind = pcrc_pkg::CMD_TICK;
      pcrc_pkg::OP_GO:    q_cmd.kind = pcrc_pkg::CMD_GO;
      pcrc_pkg::OP_SEED:  q_cmd.kind = pcrc_pkg::CMD_SEED;
      pcrc_pkg::OP_CLEAR: q_cmd.kind = pcrc_pkg::CMD_CLEAR;
      default:            q_cmd.kind = pcrc_pkg::CMD_NOP;
    endcase
  end

endmodule

// ----- rtl/core/pcrc_queue.sv -----
// ----------------------------------------------------------------------------
// pcrc_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module pcrc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pcrc_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output pcrc_pkg::cmd_t  head_cmd
);

  pcrc_pkg::cmd_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head_cmd  = ent_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/pcrc_back.sv -----
// ----------------------------------------------------------------------------
// pcrc_back
// Executes commands: word FIFO, LFSR shifting, go/run control, result beat.
// ----------------------------------------------------------------------------
module pcrc_back #(
  parameter int BITS_PER_TICK = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pcrc_pkg::cfg_t  cfg,
  input  logic            cfg_kick,
  input  logic            q_valid,
  input  pcrc_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output pcrc_pkg::res_t  out_res
);

  logic [31:0] mem_r [pcrc_pkg::FifoDepth];
  logic [3:0]  head_r, head_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [5:0]  bits_r, bits_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        run_r, run_nxt;
  logic        go_r, go_nxt;
  logic [5:0]  lwid_r, lwid_nxt;
  logic [5:0]  lpw_r, lpw_nxt;
  logic [31:0] lpoly_r, lpoly_nxt;
  logic        llsb_r, llsb_nxt;
  logic        out_valid_r;
  pcrc_pkg::res_t res_r, res_nxt;

  logic        wr_en;
  logic [3:0]  wr_idx;
  logic        fire, start, irq, drop;
  logic [4:0]  cap;

  // tick datapath
  logic        ld;
  logic [31:0] e_word, e_poly, e_mask;
  logic [5:0]  e_wid, e_pw, bl, pos;
  logic        e_lsb, fb;
  logic [3:0]  e_head;
  logic [4:0]  e_count;
  logic [4:0]  msb_idx;
  logic [31:0] r;

  assign cap       = pcrc_pkg::capacity(cfg.word_bits);
  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign fire      = q_pop;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    ld      = (bits_r == 6'd0);
    e_word  = ld ? mem_r[head_r] : cur_r;
    e_wid   = ld ? pcrc_pkg::clamp_width(cfg.word_bits) : lwid_r;
    e_pw    = ld ? pcrc_pkg::clamp_width(cfg.poly_width) : lpw_r;
    e_mask  = pcrc_pkg::width_mask(e_pw);
    e_poly  = ld ? ((cfg.polynomial | 32'd1) & e_mask) : lpoly_r;
    e_lsb   = ld ? cfg.lsb_first : llsb_r;
    e_head  = head_r + {3'd0, ld};
    e_count = count_r - {4'd0, ld};
    msb_idx = 5'(e_pw - 6'd1);
    r       = rem_r & e_mask;
    bl      = ld ? e_wid : bits_r;
    pos     = 6'd0;
    fb      = 1'b0;
    for (int n = 0; n < BITS_PER_TICK; n++) begin
      if (bl != 6'd0) begin
        pos = e_lsb ? (e_wid - bl) : (bl - 6'd1);
        fb  = r[msb_idx] ^ e_word[pos[4:0]];
        r   = (r << 1) & e_mask;
        if (fb) begin
          r = r ^ e_poly;
        end
        bl = bl - 6'd1;
      end
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    bits_nxt  = bits_r;
    rem_nxt   = rem_r;
    run_nxt   = run_r;
    go_nxt    = go_r;
    lwid_nxt  = lwid_r;
    lpw_nxt   = lpw_r;
    lpoly_nxt = lpoly_r;
    llsb_nxt  = llsb_r;
    wr_en     = 1'b0;
    wr_idx    = head_r + count_r[3:0];
    start     = 1'b0;
    irq       = 1'b0;
    drop      = 1'b0;
    if (fire) begin
      unique case (q_cmd.kind)
        pcrc_pkg::CMD_PUSH: begin
          if (count_r >= cap) begin
            drop = 1'b1;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 5'd1;
            start     = 1'b1;
          end
        end
        pcrc_pkg::CMD_TICK: begin
          if (run_r && cfg.enable && go_r && !q_cmd.hold) begin
            if (bits_r == 6'd0 && count_r == 5'd0) begin
              run_nxt = 1'b0;
              go_nxt  = 1'b0;
              irq     = !cfg.irq_on_empty;
            end else begin
              cur_nxt   = e_word;
              lwid_nxt  = e_wid;
              lpw_nxt   = e_pw;
              lpoly_nxt = e_poly;
              llsb_nxt  = e_lsb;
              head_nxt  = e_head;
              count_nxt = e_count;
              rem_nxt   = r;
              bits_nxt  = bl;
              irq       = ld && (e_count == 5'd0) && cfg.irq_on_empty;
              if (bl == 6'd0 && e_count == 5'd0) begin
                run_nxt = 1'b0;
                go_nxt  = 1'b0;
                if (!cfg.irq_on_empty) begin
                  irq = 1'b1;
                end
              end
            end
          end
        end
        pcrc_pkg::CMD_GO: begin
          go_nxt = 1'b1;
          start  = 1'b1;
        end
        pcrc_pkg::CMD_SEED: rem_nxt = q_cmd.data;
        pcrc_pkg::CMD_CLEAR: begin
          head_nxt  = 4'd0;
          count_nxt = 5'd0;
          cur_nxt   = 32'd0;
          bits_nxt  = 6'd0;
          rem_nxt   = 32'd0;
          run_nxt   = 1'b0;
          go_nxt    = 1'b0;
          lwid_nxt  = 6'd1;
          lpw_nxt   = 6'd1;
          lpoly_nxt = 32'd1;
          llsb_nxt  = 1'b0;
        end
        default: ;
      endcase
    end
    if ((start || cfg_kick) && cfg.enable && go_nxt && !run_nxt && count_nxt != 5'd0) begin
      run_nxt = 1'b1;
    end
    res_nxt.crc_value       = rem_nxt;
    res_nxt.words_queued    = count_nxt;
    res_nxt.queue_empty     = (count_nxt == 5'd0);
    res_nxt.queue_full      = (count_nxt >= cap);
    res_nxt.go_flag         = go_nxt;
    res_nxt.busy_res        = run_nxt;
    res_nxt.interrupt_pulse = irq;
    res_nxt.word_dropped    = drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= 4'd0;
      count_r     <= 5'd0;
      cur_r       <= 32'd0;
      bits_r      <= 6'd0;
      rem_r       <= 32'd0;
      run_r       <= 1'b0;
      go_r        <= 1'b0;
      lwid_r      <= 6'd1;
      lpw_r       <= 6'd1;
      lpoly_r     <= 32'd1;
      llsb_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      bits_r      <= bits_nxt;
      rem_r       <= rem_nxt;
      run_r       <= run_nxt;
      go_r        <= go_nxt;
      lwid_r      <= lwid_nxt;
      lpw_r       <= lpw_nxt;
      lpoly_r     <= lpoly_nxt;
      llsb_r      <= llsb_nxt;
      out_valid_r <= fire || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= q_cmd.data;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- rtl/core/programmable_crc_engine_fifo_core.sv -----
// Each command passes through the two-entry queue and the back end, which
// registers its result beat; result-side stalls can hold the beat back.
// Throughput: one input beat and one result beat per cycle while out_ready
// stays high; the back end updates state and registers a result per command.
// Up to BITS_PER_TICK data bits pass through the LFSR on each tick.
// Reset (rst_n low, synchronous) clears control, registers and remainder.
// ----------------------------------------------------------------------------
// programmable_crc_engine_fifo_core
// Programmable CRC engine with a word FIFO: config registers, front decode,
// command queue and execution back end.
// ----------------------------------------------------------------------------
module programmable_crc_engine_fifo_core #(
  parameter int BITS_PER_TICK = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_data_word,
  input  logic        in_hold,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_crc_value,
  output logic [4:0]  out_words_queued,
  output logic        out_queue_empty,
  output logic        out_queue_full,
  output logic        out_go_flag,
  output logic        out_busy_res,
  output logic        out_interrupt_pulse,
  output logic        out_word_dropped
);

  pcrc_pkg::cfg_t cfg_r, cfg_nxt;
  logic           kick_r, kick_nxt;
  logic           q_push, q_full, q_pop, q_valid;
  pcrc_pkg::cmd_t f_cmd, h_cmd;
  pcrc_pkg::res_t res;

  always_comb begin
    cfg_nxt  = cfg_r;
    kick_nxt = 1'b0;
    if (cfg_we) begin
      kick_nxt = 1'b1;
      unique case (cfg_index)
        pcrc_pkg::CFG_ENABLE:       cfg_nxt.enable       = cfg_wdata[0];
        pcrc_pkg::CFG_WORD_BITS:    cfg_nxt.word_bits    = cfg_wdata[5:0];
        pcrc_pkg::CFG_POLY_WIDTH:   cfg_nxt.poly_width   = cfg_wdata[5:0];
        pcrc_pkg::CFG_POLYNOMIAL:   cfg_nxt.polynomial   = cfg_wdata;
        pcrc_pkg::CFG_LSB_FIRST:    cfg_nxt.lsb_first    = cfg_wdata[0];
        pcrc_pkg::CFG_IRQ_ON_EMPTY: cfg_nxt.irq_on_empty = cfg_wdata[0];
        default:                    kick_nxt             = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 1'b0;
      cfg_r.word_bits    <= 6'd1;
      cfg_r.poly_width   <= 6'd1;
      cfg_r.polynomial   <= 32'd0;
      cfg_r.lsb_first    <= 1'b0;
      cfg_r.irq_on_empty <= 1'b0;
      kick_r             <= 1'b0;
    end else begin
      cfg_r  <= cfg_nxt;
      kick_r <= kick_nxt;
    end
  end

  pcrc_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_data_word (in_data_word),
    .in_hold      (in_hold),
    .cfg          (cfg_r),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_cmd        (f_cmd)
  );

  pcrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (f_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (h_cmd)
  );

  pcrc_back #(
    .BITS_PER_TICK (BITS_PER_TICK)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_kick  (kick_r),
    .q_valid   (q_valid),
    .q_cmd     (h_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_crc_value       = res.crc_value;
  assign out_words_queued    = res.words_queued;
  assign out_queue_empty     = res.queue_empty;
  assign out_queue_full      = res.queue_full;
  assign out_go_flag         = res.go_flag;
  assign out_busy_res        = res.busy_res;
  assign out_interrupt_pulse = res.interrupt_pulse;
  assign out_word_dropped    = res.word_dropped;

endmodule

// ----- bench/tb_programmable_crc_engine_fifo_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_programmable_crc_engine_fifo_core
// Self-checking bench for the programmable CRC engine with its word FIFO.
// A cycle-free model of the engine predicts the status beat for every
// accepted command. A monitor checks each result beat against the oldest
// prediction, field by field. Directed tests cover reset state, both bit
// orders, both interrupt sources, overflow, clear and undefined operations.
// Random frames of seed, push, go and tick traffic then run under several
// register settings, with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_programmable_crc_engine_fifo_core;

  localparam int BitsPerTick     = 1;
  localparam int CycleLimit      = 200000;
  localparam int DrainCycles     = 4;
  localparam int BeatsPerSetting = 60;
  localparam int RandomBeats     = 240;
  localparam int TickGuard       = 400;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [2:0]  cfg_index    = '0;
  logic [31:0] cfg_wdata    = '0;
  logic        in_valid     = 1'b0;
  logic [2:0]  in_operation = '0;
  logic [31:0] in_data_word = '0;
  logic        in_hold      = 1'b0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_crc_value;
  logic [4:0]  out_words_queued;
  logic        out_queue_empty;
  logic        out_queue_full;
  logic        out_go_flag;
  logic        out_busy_res;
  logic        out_interrupt_pulse;
  logic        out_word_dropped;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int beats_sent    = 0;
  int cycle_count   = 0;

  pcrc_pkg::res_t crc_expect_q[$];

  // engine model: registers
  logic        reg_enable;
  logic [5:0]  reg_dw;
  logic [5:0]  reg_pw;
  logic [31:0] reg_poly;
  logic        reg_lsb;
  logic        reg_irq_empty;
  // engine model: runtime state
  logic [31:0] fifo_mem [pcrc_pkg::FifoDepth];
  logic [3:0]  q_head;
  logic [4:0]  q_count;
  logic [31:0] cur_word;
  logic [5:0]  bits_left;
  logic [31:0] crc_rem;
  logic        eng_running;
  logic        eng_go;
  logic [5:0]  lat_dw;
  logic [5:0]  lat_pw;
  logic [31:0] lat_poly;
  logic        lat_lsb;

  programmable_crc_engine_fifo_core #(
    .BITS_PER_TICK(BitsPerTick)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_data_word       (in_data_word),
    .in_hold            (in_hold),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_crc_value      (out_crc_value),
    .out_words_queued   (out_words_queued),
    .out_queue_empty    (out_queue_empty),
    .out_queue_full     (out_queue_full),
    .out_go_flag        (out_go_flag),
    .out_busy_res       (out_busy_res),
    .out_interrupt_pulse(out_interrupt_pulse),
    .out_word_dropped   (out_word_dropped)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [5:0] eff_width(input logic [5:0] w);
    return (w == 6'd0) ? 6'd1 : ((w > 6'd32) ? 6'd32 : w);
  endfunction

  function automatic logic [31:0] low_mask(input logic [5:0] w);
    logic [32:0] ones;
    ones = (33'd1 << w) - 33'd1;
    return ones[31:0];
  endfunction

  function automatic logic [4:0] room_for(input logic [5:0] dw);
    logic [5:0] w;
    w = eff_width(dw);
    return (w <= 6'd8) ? 5'd16 : ((w <= 6'd16) ? 5'd8 : 5'd4);
  endfunction

  function automatic void try_start();
    if (reg_enable && eng_go && !eng_running && q_count != 5'd0) begin
      eng_running = 1'b1;
    end
  endfunction

  function automatic void clear_engine();
    for (int i = 0; i < pcrc_pkg::FifoDepth; i++) begin
      fifo_mem[i] = '0;
    end
    q_head      = '0;
    q_count     = '0;
    cur_word    = '0;
    bits_left   = '0;
    crc_rem     = '0;
    eng_running = 1'b0;
    eng_go      = 1'b0;
    lat_dw      = 6'd1;
    lat_pw      = 6'd1;
    lat_poly    = 32'd1;
    lat_lsb     = 1'b0;
  endfunction

  function automatic void reset_engine();
    reg_enable    = 1'b0;
    reg_dw        = 6'd1;
    reg_pw        = 6'd1;
    reg_poly      = '0;
    reg_lsb       = 1'b0;
    reg_irq_empty = 1'b0;
    clear_engine();
  endfunction

  function automatic void apply_reg_write(input pcrc_pkg::cfg_idx_t idx,
                                          input logic [31:0] val);
    case (idx)
      pcrc_pkg::CFG_ENABLE:       reg_enable    = val[0];
      pcrc_pkg::CFG_WORD_BITS:    reg_dw        = val[5:0];
      pcrc_pkg::CFG_POLY_WIDTH:   reg_pw        = val[5:0];
      pcrc_pkg::CFG_POLYNOMIAL:   reg_poly      = val;
      pcrc_pkg::CFG_LSB_FIRST:    reg_lsb       = val[0];
      pcrc_pkg::CFG_IRQ_ON_EMPTY: reg_irq_empty = val[0];
      default: return;
    endcase
    try_start();
  endfunction

  function automatic logic load_next();
    cur_word  = fifo_mem[q_head];
    q_head    = q_head + 4'd1;
    q_count   = q_count - 5'd1;
    lat_dw    = eff_width(reg_dw);
    lat_pw    = eff_width(reg_pw);
    lat_poly  = (reg_poly | 32'd1) & low_mask(lat_pw);
    lat_lsb   = reg_lsb;
    bits_left = lat_dw;
    return (q_count == 5'd0) && reg_irq_empty;
  endfunction

  function automatic void shift_word();
    logic [31:0] m;
    logic [31:0] r;
    logic        fb;
    int          pos;
    m = low_mask(lat_pw);
    r = crc_rem & m;
    for (int n = 0; n < BitsPerTick && bits_left != 6'd0; n++) begin
      pos = lat_lsb ? (int'(lat_dw) - int'(bits_left)) : (int'(bits_left) - 1);
      fb  = r[lat_pw - 6'd1] ^ cur_word[pos[4:0]];
      r   = (r << 1) & m;
      if (fb) begin
        r = r ^ lat_poly;
      end
      bits_left = bits_left - 6'd1;
    end
    crc_rem = r;
  endfunction

  function automatic logic finish_run();
    eng_running = 1'b0;
    eng_go      = 1'b0;
    return !reg_irq_empty;
  endfunction

  function automatic pcrc_pkg::res_t predict_beat(input logic [2:0] op,
                                                  input logic [31:0] data,
                                                  input logic hold);
    pcrc_pkg::res_t res;
    logic irq;
    logic dropped;
    irq     = 1'b0;
    dropped = 1'b0;
    case (op)
      pcrc_pkg::OP_PUSH: begin
        if (q_count >= room_for(reg_dw)) begin
          dropped = 1'b1;
        end else begin
          fifo_mem[q_head + q_count[3:0]] = data & low_mask(eff_width(reg_dw));
          q_count = q_count + 5'd1;
          try_start();
        end
      end
      pcrc_pkg::OP_TICK: begin
        if (eng_running && reg_enable && eng_go && !hold) begin
          if (bits_left == 6'd0 && q_count == 5'd0) begin
            irq = finish_run();
          end else begin
            if (bits_left == 6'd0) begin
              irq = load_next();
            end
            shift_word();
            if (bits_left == 6'd0 && q_count == 5'd0) begin
              if (finish_run()) begin
                irq = 1'b1;
              end
            end
          end
        end
      end
      pcrc_pkg::OP_GO: begin
        eng_go = 1'b1;
        try_start();
      end
      pcrc_pkg::OP_SEED:  crc_rem = data;
      pcrc_pkg::OP_CLEAR: clear_engine();
      default: ;
    endcase
    res.crc_value       = crc_rem;
    res.words_queued    = q_count;
    res.queue_empty     = (q_count == 5'd0);
    res.queue_full      = (q_count >= room_for(reg_dw));
    res.go_flag         = eng_go;
    res.busy_res        = eng_running;
    res.interrupt_pulse = irq;
    res.word_dropped    = dropped;
    return res;
  endfunction

  // valid stays high after acceptance; the next call or drain_engine moves it
  task automatic send_beat(input logic [2:0] op, input logic [31:0] data, input logic hold);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_word <= data;
    in_hold      <= hold;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    crc_expect_q.push_back(predict_beat(op, data, hold));
    if (op <= 3'(pcrc_pkg::OP_CLEAR)) begin
      beats_sent++;
    end
  endtask

  task automatic drain_engine();
    in_valid <= 1'b0;
    while (crc_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input pcrc_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg_write(idx, val);
  endtask

  task automatic program_engine(input logic en, input logic [5:0] dw, input logic [5:0] pw,
                                input logic [31:0] poly, input logic lsb,
                                input logic irq_sel);
    drain_engine();
    write_reg(pcrc_pkg::CFG_ENABLE, {31'd0, en});
    write_reg(pcrc_pkg::CFG_WORD_BITS, {26'd0, dw});
    write_reg(pcrc_pkg::CFG_POLY_WIDTH, {26'd0, pw});
    write_reg(pcrc_pkg::CFG_POLYNOMIAL, poly);
    write_reg(pcrc_pkg::CFG_LSB_FIRST, {31'd0, lsb});
    write_reg(pcrc_pkg::CFG_IRQ_ON_EMPTY, {31'd0, irq_sel});
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    // registers at reset value: engine disabled, one-bit words
    send_beat(pcrc_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b0);
    send_beat(pcrc_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0);
    send_beat(pcrc_pkg::OP_GO, 32'd0, 1'b0);
  endtask

  task automatic test_msb_first_crc();
    program_engine(1'b1, 6'd4, 6'd8, 32'h0000_0007, 1'b0, 1'b0);
    send_beat(pcrc_pkg::OP_SEED, 32'd0, 1'b0);
    send_beat(pcrc_pkg::OP_PUSH, 32'h0000_00A5, 1'b0);
    send_beat(pcrc_pkg::OP_GO, 32'd0, 1'b0);
    send_beat(pcrc_pkg::OP_TICK, 32'd0, 1'b1);
    repeat (4) send_beat(pcrc_pkg::OP_TICK, 32'd0, 1'b0);
    send_beat(pcrc_pkg::OP_TICK, 32'd0, 1'b0);
  endtask

  task automatic test_lsb_first_irq_on_empty();
    // width zero and width above range both clamp
    program_engine(1'b1, 6'd0, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_beat(pcrc_pkg::OP_SEED, 32'hFFFF_FFFF, 1'b0);
    send_beat(pcrc_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0);
    send_beat(pcrc_pkg::OP_PUSH, 32'd0, 1'b0);
    send_beat(pcrc_pkg::OP_GO, 32'd0, 1'b0);
    repeat (3) send_beat(pcrc_pkg::OP_TICK, 32'd0, 1'b0);
  endtask

  task automatic test_overflow_and_clear();
    logic [2:0] op;
    program_engine(1'b0, 6'd17, 6'd32, 32'h04C1_1DB7, 1'b0, 1'b0);
    repeat (5) send_beat(pcrc_pkg::OP_PUSH, $urandom, 1'b0);
    send_beat(pcrc_pkg::OP_CLEAR, 32'd0, 1'b0);
    op = 3'(pcrc_pkg::OP_CLEAR);
    repeat (3) begin
      op = op + 3'd1;
      send_beat(op, $urandom, 1'b1);
    end
  endtask

  task automatic run_frame();
    int   n_words;
    int   n_ticks;
    int   roll;
    logic go_first;
    go_first = ($urandom_range(9) < 3);
    if ($urandom_range(3) == 0) begin
      send_beat(pcrc_pkg::OP_SEED, $urandom, 1'b0);
    end
    if (go_first) begin
      send_beat(pcrc_pkg::OP_GO, $urandom, 1'b0);
    end
    n_words = $urandom_range(1, int'(room_for(reg_dw)) + 1);
    repeat (n_words) send_beat(pcrc_pkg::OP_PUSH, $urandom, 1'b0);
    if (!go_first) begin
      send_beat(pcrc_pkg::OP_GO, $urandom, 1'b0);
    end
    n_ticks = 0;
    while ((eng_running || n_ticks < 2) && n_ticks < TickGuard) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_beat(3'($urandom_range(7)), $urandom, 1'($urandom_range(1)));
      end else begin
        send_beat(pcrc_pkg::OP_TICK, $urandom, roll < 10);
      end
      n_ticks++;
    end
  endtask

  task automatic test_random_traffic(input int target);
    int         stop_at;
    int         cfg_mark;
    int         pick;
    logic [5:0] dw;
    logic [5:0] pw;
    stop_at  = beats_sent + target;
    cfg_mark = beats_sent;
    while (beats_sent < stop_at) begin
      if (beats_sent - cfg_mark >= BeatsPerSetting) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          dw = 6'($urandom_range(1, 8));
        end else if (pick < 85) begin
          dw = 6'($urandom_range(9, 16));
        end else if (pick < 95) begin
          dw = 6'($urandom_range(17, 32));
        end else begin
          dw = 6'($urandom_range(63));
        end
        pw = ($urandom_range(9) != 0) ? 6'($urandom_range(1, 32)) : 6'($urandom_range(63));
        program_engine($urandom_range(9) != 0, dw, pw, $urandom,
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        cfg_mark = beats_sent;
      end
      run_frame();
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    pcrc_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (crc_expect_q.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_count++;
      end else begin
        want = crc_expect_q.pop_front();
        check_field("crc_value", want.crc_value, out_crc_value);
        check_field("words_queued", 32'(want.words_queued), 32'(out_words_queued));
        check_field("queue_empty", 32'(want.queue_empty), 32'(out_queue_empty));
        check_field("queue_full", 32'(want.queue_full), 32'(out_queue_full));
        check_field("go_flag", 32'(want.go_flag), 32'(out_go_flag));
        check_field("busy_res", 32'(want.busy_res), 32'(out_busy_res));
        check_field("interrupt_pulse", 32'(want.interrupt_pulse), 32'(out_interrupt_pulse));
        check_field("word_dropped", 32'(want.word_dropped), 32'(out_word_dropped));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    reset_engine();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 72;
    test_reset_state();
    test_msb_first_crc();
    test_lsb_first_irq_on_empty();
    test_overflow_and_clear();

    program_engine(1'b1, 6'd32, 6'd32, 32'hFFFF_FFFF, 1'b1, 1'b0);
    test_random_traffic(RandomBeats);

    send_idle_pct = 72;
    recv_idle_pct = 30;
    program_engine(1'b1, 6'd1, 6'd1, 32'd0, 1'b0, 1'b1);
    test_random_traffic(RandomBeats);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_engine(1'b1, 6'd63, 6'd0, $urandom, 1'b0, 1'b0);
    test_random_traffic(RandomBeats);

    drain_engine();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- programmable_crc_engine_fifo_core.f -----
rtl/core/pcrc_pkg.sv
rtl/core/pcrc_front.sv
rtl/core/pcrc_queue.sv
rtl/core/pcrc_back.sv
rtl/core/programmable_crc_engine_fifo_core.sv
bench/tb_programmable_crc_engine_fifo_core.sv
